/* hw/rtl/egd_pkg.sv */
// Package for the elevator group dispatcher.
// Holds the command, action, register index and sequencer state types.
// No dependencies.
`timescale 1ns / 1ps

package egd_pkg;

   typedef enum logic [1:0] {
      CMD_HALL_UP   = 2'd0,
      CMD_HALL_DOWN = 2'd1,
      CMD_CAR       = 2'd2,
      CMD_DECIDE    = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ACT_UP        = 3'd0,
      ACT_DOWN      = 3'd1,
      ACT_OPEN_UP   = 3'd2,
      ACT_OPEN_DOWN = 3'd3,
      ACT_STAY      = 3'd4
   } action_type;

   typedef enum logic {
      REG_FLOORS = 1'b0,
      REG_LIFTS  = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_SEND
   } state_type;

   localparam int CFG_W        = 5;
   localparam int FLOORS_CFG_W = 5;
   localparam int LIFTS_CFG_W  = 3;
   localparam logic [FLOORS_CFG_W-1:0] FLOORS_RESET = 5'd16;
   localparam logic [LIFTS_CFG_W-1:0]  LIFTS_RESET  = 3'd4;

endpackage

/* hw/rtl/elevator_group_dispatcher.sv */
// Elevator group dispatcher top level: request flags, lift state and the
// per-lift decision sequencer with one shared decision unit.
// Depends on egd_pkg.
// Operation: a press item is taken and gives no result. A decide item runs the
// shared decision unit once per lift: it decides in ST_CALC, then the result
// sits in the output register in ST_SEND until taken. The next item is accepted
// the cycle after the last result of a round is taken. Synchronous active-high
// reset clears all flags, parks every lift at floor 0 heading up and stopped,
// and restores 16 floors, 4 lifts.
`timescale 1ns / 1ps

module elevator_group_dispatcher
   import egd_pkg::*;
#(
   parameter int MAX_FLOORS = 16,
   parameter int MAX_LIFTS  = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // floor [3:0], lift [5:4], zeros above
   input  logic [1:0] req_tuser,   // command [1:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // lift_index [1:0], action [4:2], zeros above
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int PW = (MAX_FLOORS > 2) ? $clog2(MAX_FLOORS) : 1;
   localparam int NW = $clog2(MAX_FLOORS + 1);
   localparam int CW = (NW > FLOORS_CFG_W) ? NW : FLOORS_CFG_W;
   localparam int LW = (MAX_LIFTS > 1) ? $clog2(MAX_LIFTS) : 1;
   localparam int KW = $clog2(MAX_LIFTS + 1);
   localparam int KCW = (KW > LIFTS_CFG_W) ? KW : LIFTS_CFG_W;

   state_type state_ff, state_in;
   logic [FLOORS_CFG_W-1:0] floors_ff;
   logic [LIFTS_CFG_W-1:0]  lifts_ff;
   logic [PW-1:0]          pos_ff     [MAX_LIFTS];
   logic                   up_ff      [MAX_LIFTS];
   logic                   stopped_ff [MAX_LIFTS];
   logic [MAX_FLOORS-1:0]  car_ff     [MAX_LIFTS];
   logic [MAX_FLOORS-1:0]  hall_up_ff, hall_dn_ff;
   logic [LW-1:0]          idx_ff;
   logic                   sent_up_ff, sent_dn_ff;
   action_type             act_ff;
   logic                   last_ff;

   logic [CW-1:0]  floors_ext;
   logic [NW-1:0]  n_floors;
   logic [PW-1:0]  top_floor;
   logic [KCW-1:0] lifts_ext;
   logic [KW-1:0]  n_lifts;
   logic [3:0]     req_floor;
   logic [1:0]     req_lift;
   command_type    req_cmd;
   logic           req_fire;
   logic           rsp_fire;
   logic [MAX_FLOORS-1:0] press_mask;
   logic           press_ok;

   logic [PW-1:0]         p;
   logic [MAX_FLOORS-1:0] bitp, above, below, mall, car, ahead, hall;
   logic up, car_bit, conflict, stop, cont, opp;
   logic hall_dn_here, hall_up_here, hall_above, hall_below;
   action_type act;
   logic eff_open, eff_move, eff_up, set_sent_up, set_sent_dn;
   logic [PW-1:0] new_pos;
   logic is_last;

   // Configuration, clamped to the supported ranges.
   always_comb begin
      floors_ext = CW'(floors_ff);
      if (floors_ext < CW'(2)) begin
         n_floors = NW'(2);
      end else if (floors_ext > CW'(MAX_FLOORS)) begin
         n_floors = NW'(MAX_FLOORS);
      end else begin
         n_floors = NW'(floors_ext);
      end
      top_floor = PW'(n_floors - NW'(1));
      lifts_ext = KCW'(lifts_ff);
      if (lifts_ext < KCW'(1)) begin
         n_lifts = KW'(1);
      end else if (lifts_ext > KCW'(MAX_LIFTS)) begin
         n_lifts = KW'(MAX_LIFTS);
      end else begin
         n_lifts = KW'(lifts_ext);
      end
   end

   assign req_floor = req_tdata[3:0];
   assign req_lift  = req_tdata[5:4];
   assign req_cmd   = command_type'(req_tuser);
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign press_ok  = {3'b000, req_floor} < 7'(n_floors);

   always_comb begin
      for (int b = 0; b < MAX_FLOORS; b++) begin
         press_mask[b] = ({3'b000, req_floor} == 7'(b));
      end
   end

   // Shared decision unit, applied to lift idx_ff.
   always_comb begin
      p   = (pos_ff[idx_ff] > top_floor) ? top_floor : pos_ff[idx_ff];
      up  = up_ff[idx_ff];
      car = car_ff[idx_ff];
      for (int b = 0; b < MAX_FLOORS; b++) begin
         bitp[b]  = (PW'(b) == p);
         above[b] = (PW'(b) > p);
         below[b] = (PW'(b) < p);
         mall[b]  = (NW'(b) < n_floors);
      end
      ahead = car & mall & (up ? above : below);
      hall  = (hall_up_ff | hall_dn_ff) & mall;
      hall_above   = |(hall & above);
      hall_below   = |(hall & below);
      hall_dn_here = |(hall_dn_ff & bitp);
      hall_up_here = |(hall_up_ff & bitp);
      car_bit = |(car & bitp);
      conflict = 1'b0;
      for (int l = 0; l < MAX_LIFTS; l++) begin
         if ((KW'(l) < n_lifts) && (LW'(l) != idx_ff) && (pos_ff[l] == p)
               && stopped_ff[l] && up_ff[l]) begin
            conflict = 1'b1;
         end
      end
      stop = car_bit && !conflict;
      cont = !car_bit && (|ahead) && (up ? (p != top_floor) : (p != '0));
      opp  = !(|ahead) && (up ? (p != '0) : (p != top_floor));

      eff_open    = 1'b0;
      eff_move    = 1'b0;
      eff_up      = up;
      set_sent_up = 1'b0;
      set_sent_dn = 1'b0;
      act         = ACT_STAY;
      if (stop) begin
         eff_open = 1'b1;
         act      = up ? ACT_OPEN_UP : ACT_OPEN_DOWN;
      end else if (cont) begin
         eff_move = 1'b1;
         act      = up ? ACT_UP : ACT_DOWN;
      end else if (hall_dn_here) begin
         eff_open = 1'b1;
         eff_up   = 1'b0;
         act      = ACT_OPEN_DOWN;
      end else if (hall_up_here) begin
         eff_open = 1'b1;
         eff_up   = 1'b1;
         act      = ACT_OPEN_UP;
      end else if (hall_below) begin
         eff_up = 1'b0;
         if (!sent_dn_ff) begin
            set_sent_dn = 1'b1;
            eff_move    = 1'b1;
            act         = ACT_DOWN;
         end else begin
            eff_open = 1'b1;
            act      = ACT_OPEN_DOWN;
         end
      end else if (hall_above) begin
         eff_up = 1'b1;
         if (!sent_up_ff) begin
            set_sent_up = 1'b1;
            eff_move    = 1'b1;
            act         = ACT_UP;
         end else begin
            eff_open = 1'b1;
            act      = ACT_OPEN_UP;
         end
      end else if (opp) begin
         eff_move = 1'b1;
         eff_up   = !up;
         act      = up ? ACT_DOWN : ACT_UP;
      end else if (p != '0) begin
         eff_open = 1'b1;
         eff_up   = 1'b0;
         act      = ACT_OPEN_DOWN;
      end else if (p != top_floor) begin
         eff_open = 1'b1;
         eff_up   = 1'b1;
         act      = ACT_OPEN_UP;
      end
      new_pos = p;
      if (eff_move) begin
         if (eff_up) begin
            new_pos = p + PW'(1);
         end else if (p != '0) begin
            new_pos = p - PW'(1);
         end
      end
      is_last = (KW'(idx_ff) == n_lifts - KW'(1));
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_cmd == CMD_DECIDE) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_fire) begin
               state_in = last_ff ? ST_IDLE : ST_CALC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_CALC: ;
         ST_SEND: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   assign rsp_tdata = {3'b000, act_ff, 2'(idx_ff)};
   assign rsp_tlast = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         floors_ff  <= FLOORS_RESET;
         lifts_ff   <= LIFTS_RESET;
         hall_up_ff <= '0;
         hall_dn_ff <= '0;
         idx_ff     <= '0;
         sent_up_ff <= 1'b0;
         sent_dn_ff <= 1'b0;
         for (int l = 0; l < MAX_LIFTS; l++) begin
            pos_ff[l]     <= '0;
            up_ff[l]      <= 1'b1;
            stopped_ff[l] <= 1'b1;
            car_ff[l]     <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (reg_index_type'(csr_index))
               REG_FLOORS: floors_ff <= csr_wdata[FLOORS_CFG_W-1:0];
               REG_LIFTS:  lifts_ff  <= csr_wdata[LIFTS_CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            idx_ff     <= '0;
            sent_up_ff <= 1'b0;
            sent_dn_ff <= 1'b0;
            if (press_ok) begin
               case (req_cmd)
                  CMD_HALL_UP:   hall_up_ff <= hall_up_ff | press_mask;
                  CMD_HALL_DOWN: hall_dn_ff <= hall_dn_ff | press_mask;
                  CMD_CAR: begin
                     for (int l = 0; l < MAX_LIFTS; l++) begin
                        if (({2'b00, req_lift} == 4'(l)) && (KW'(l) < n_lifts)) begin
                           car_ff[l] <= car_ff[l] | press_mask;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         if (state_ff == ST_CALC) begin
            pos_ff[idx_ff] <= new_pos;
            up_ff[idx_ff]  <= eff_up;
            stopped_ff[idx_ff] <= !eff_move;
            if (eff_open) begin
               car_ff[idx_ff] <= car & ~bitp;
               if (eff_up) begin
                  hall_up_ff <= hall_up_ff & ~bitp;
               end else begin
                  hall_dn_ff <= hall_dn_ff & ~bitp;
               end
            end
            if (set_sent_up) begin
               sent_up_ff <= 1'b1;
            end
            if (set_sent_dn) begin
               sent_dn_ff <= 1'b1;
            end
         end
         if (state_ff == ST_SEND && rsp_fire && !last_ff) begin
            idx_ff <= idx_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         act_ff  <= act;
         last_ff <= is_last;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a result is pending");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:2] == ACT_UP || rsp_tdata[4:2] == ACT_DOWN
         || rsp_tdata[4:2] == ACT_OPEN_UP || rsp_tdata[4:2] == ACT_OPEN_DOWN
         || rsp_tdata[4:2] == ACT_STAY))
      else $error("result carries an undefined action");

   a_press_no_round: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd != CMD_DECIDE) |=> state_ff == ST_IDLE)
      else $error("press item started a round");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> (state_ff == ST_IDLE && req_tready))
      else $error("round did not end after the last item");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (KW'(idx_ff) == n_lifts - KW'(1)))
      else $error("last flag on the wrong lift");

endmodule

/* test/elevator_group_dispatcher_test.sv */
// Self-checking testbench for the elevator group dispatcher.
// A scoreboard class predicts every lift action from the press and decide items; plain
// tasks drive the request and register ports, an always block rsp_tready. Depends on egd_pkg.
`timescale 1ns / 1ps

module elevator_group_dispatcher_test
   import egd_pkg::*;
;

   localparam int FLOOR_COUNT = 16;
   localparam int LIFT_COUNT  = 4;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [1:0] lift_index;
      action_type action;
      logic       last;
   } lift_action_type;

   class dispatch_scoreboard;
      logic [FLOORS_CFG_W-1:0] floors_reg;
      logic [LIFTS_CFG_W-1:0]  lifts_reg;
      logic [3:0]  position [LIFT_COUNT];
      bit          heading_up [LIFT_COUNT];
      bit          stopped [LIFT_COUNT];
      logic [15:0] hall_up;
      logic [15:0] hall_down;
      logic [15:0] car [LIFT_COUNT];
      bit          sent_up;
      bit          sent_down;
      lift_action_type pending_actions[$];
      int          errors;

      function new();
         int l;
         floors_reg = FLOORS_RESET;
         lifts_reg = LIFTS_RESET;
         for (l = 0; l < LIFT_COUNT; l++) begin
            position[l] = '0;
            heading_up[l] = 1'b1;
            stopped[l] = 1'b1;
            car[l] = '0;
         end
         hall_up = '0;
         hall_down = '0;
         errors = 0;
      endfunction

      function int num_floors();
         int n;
         n = floors_reg;
         if (n < 2) n = 2;
         if (n > FLOOR_COUNT) n = FLOOR_COUNT;
         return n;
      endfunction

      function int num_lifts();
         int k;
         k = lifts_reg;
         if (k < 1) k = 1;
         if (k > LIFT_COUNT) k = LIFT_COUNT;
         return k;
      endfunction

      function void set_register(reg_index_type idx, logic [CFG_W-1:0] value);
         if (idx == REG_FLOORS) begin
            floors_reg = value[FLOORS_CFG_W-1:0];
         end else begin
            lifts_reg = value[LIFTS_CFG_W-1:0];
         end
      endfunction

      function void open_doors(int i, int p, bit up);
         logic [15:0] bit_p;
         bit_p = 16'd1 << p;
         if (up) hall_up = hall_up & ~bit_p;
         else hall_down = hall_down & ~bit_p;
         car[i] = car[i] & ~bit_p;
         heading_up[i] = up;
         stopped[i] = 1'b1;
      endfunction

      function void move_car(int i, bit up);
         if (up) position[i] = position[i] + 4'd1;
         else if (position[i] > 0) position[i] = position[i] - 4'd1;
         heading_up[i] = up;
         stopped[i] = 1'b0;
      endfunction

      function action_type choose_action(int i, int n, int k);
         logic [15:0] in_use, bit_p, above, below, ahead, hall;
         int p, l;
         bit up, stop_here, keep_going, reverse;
         if (position[i] > n - 1) position[i] = 4'(n - 1);
         p = position[i];
         bit_p = 16'd1 << p;
         in_use = 16'((32'd1 << n) - 32'd1);
         above = 16'hFFFF << (p + 1);
         below = bit_p - 16'd1;
         up = heading_up[i];
         ahead = car[i] & in_use & (up ? above : below);
         hall = (hall_up | hall_down) & in_use;
         stop_here = (car[i] & bit_p) != 0;
         keep_going = !stop_here && ahead != 0 && (up ? p != n - 1 : p != 0);
         reverse = ahead == 0 && (up ? p != 0 : p != n - 1);
         // A car button is not served while another lift stands open at that floor going up.
         for (l = 0; l < k; l++) begin
            if (l != i && position[l] == p && stopped[l] && heading_up[l]) stop_here = 1'b0;
         end
         if (stop_here) begin
            open_doors(i, p, up);
            return up ? ACT_OPEN_UP : ACT_OPEN_DOWN;
         end
         if (keep_going) begin
            move_car(i, up);
            return up ? ACT_UP : ACT_DOWN;
         end
         if ((hall_down & bit_p) != 0) begin
            open_doors(i, p, 1'b0);
            return ACT_OPEN_DOWN;
         end
         if ((hall_up & bit_p) != 0) begin
            open_doors(i, p, 1'b1);
            return ACT_OPEN_UP;
         end
         if ((hall & below) != 0) begin
            if (!sent_down) begin
               sent_down = 1'b1;
               move_car(i, 1'b0);
               return ACT_DOWN;
            end
            open_doors(i, p, 1'b0);
            return ACT_OPEN_DOWN;
         end
         if ((hall & above) != 0) begin
            if (!sent_up) begin
               sent_up = 1'b1;
               move_car(i, 1'b1);
               return ACT_UP;
            end
            open_doors(i, p, 1'b1);
            return ACT_OPEN_UP;
         end
         if (reverse) begin
            move_car(i, !up);
            return up ? ACT_DOWN : ACT_UP;
         end
         if (p != 0) begin
            open_doors(i, p, 1'b0);
            return ACT_OPEN_DOWN;
         end
         if (p != n - 1) begin
            open_doors(i, p, 1'b1);
            return ACT_OPEN_UP;
         end
         stopped[i] = 1'b1;
         return ACT_STAY;
      endfunction

      function void take_item(command_type cmd, logic [3:0] fl, logic [1:0] lf);
         int n, k, i;
         lift_action_type act;
         n = num_floors();
         k = num_lifts();
         if (cmd != CMD_DECIDE) begin
            if (fl >= n) return;
            case (cmd)
               CMD_HALL_UP: hall_up = hall_up | (16'd1 << fl);
               CMD_HALL_DOWN: hall_down = hall_down | (16'd1 << fl);
               default: if (lf < k) car[lf] = car[lf] | (16'd1 << fl);
            endcase
            return;
         end
         sent_up = 1'b0;
         sent_down = 1'b0;
         for (i = 0; i < k; i++) begin
            act.lift_index = 2'(i);
            act.action = choose_action(i, n, k);
            act.last = (i == k - 1);
            pending_actions.insert(pending_actions.size(), act);
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 200) $display("mismatch: %s", msg);
      endtask

      task check_action(logic [7:0] tdata, logic tlast);
         lift_action_type want;
         if (pending_actions.size() == 0) begin
            report($sformatf("unexpected action %0d for lift %0d", tdata[4:2], tdata[1:0]));
            return;
         end
         want = pending_actions.pop_front();
         if (tdata[1:0] !== want.lift_index)
            report($sformatf("lift index %0d, want %0d", tdata[1:0], want.lift_index));
         if (tdata[4:2] !== want.action)
            report($sformatf("lift %0d action %0d, want %0d", want.lift_index, tdata[4:2],
                             want.action));
         if (tlast !== want.last)
            report($sformatf("lift %0d last %b, want %b", want.lift_index, tlast, want.last));
      endtask

      task check_drained();
         if (pending_actions.size() != 0)
            report($sformatf("%0d actions never arrived", pending_actions.size()));
      endtask
   endclass

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = '0;   // floor [3:0], lift [5:4], zeros above
   logic [1:0]       req_tuser = CMD_HALL_UP;   // command [1:0]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;   // lift_index [1:0], action [4:2], zeros above
   logic             rsp_tlast;
   logic             csr_wr_en = 1'b0;
   logic             csr_index = REG_FLOORS;
   logic [CFG_W-1:0] csr_wdata = '0;

   dispatch_scoreboard sb;
   int tx_idle_pct = 23;
   int rx_idle_pct = 61;
   int hold_requests = 0;
   int holds_seen = 0;
   int hold_left = 0;

   elevator_group_dispatcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("FAILED: results differ");
      $finish;
   end

   always @(negedge clock) begin
      if (hold_requests != holds_seen) begin
         holds_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid === 1'b1 && rsp_tready) sb.check_action(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready === 1'b1)
            sb.take_item(command_type'(req_tuser), req_tdata[3:0], req_tdata[5:4]);
      end
   end

   task automatic send_item(input command_type cmd, input logic [3:0] fl, input logic [1:0] lf);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, lf, fl};
      req_tuser <= cmd;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic send_random_item();
      command_type cmd;
      logic [3:0] fl;
      logic [1:0] lf;
      if ($urandom_range(99) < 35) cmd = CMD_DECIDE;
      else cmd = command_type'($urandom_range(2));
      if ($urandom_range(9) == 0) fl = 4'($urandom_range(15));
      else fl = 4'($urandom_range(sb.num_floors() - 1));
      if ($urandom_range(9) == 0) lf = 2'($urandom_range(3));
      else lf = 2'($urandom_range(sb.num_lifts() - 1));
      send_item(cmd, fl, lf);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_actions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_register(idx, value);
   endtask

   initial begin
      int floors_plan [6];
      int lifts_plan [6];
      int ph;
      sb = new();
      floors_plan = '{16, 2, 31, 0, 7, 12};
      lifts_plan = '{4, 1, 7, 0, 2, 3};
      floors_plan[5] = $urandom_range(31);
      lifts_plan[5] = $urandom_range(31);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // All lifts parked at the ground floor, then a stop that another open lift blocks.
      send_item(CMD_DECIDE, 4'd0, 2'd0);
      send_item(CMD_CAR, 4'd0, 2'd0);
      send_item(CMD_DECIDE, 4'd0, 2'd0);
      send_item(CMD_CAR, 4'd15, 2'd3);
      send_item(CMD_HALL_DOWN, 4'd15, 2'd0);
      send_item(CMD_HALL_UP, 4'd0, 2'd0);
      send_item(CMD_HALL_UP, 4'd7, 2'd0);
      send_item(CMD_HALL_DOWN, 4'd3, 2'd0);
      send_item(CMD_CAR, 4'd5, 2'd1);
      repeat (4) send_item(CMD_DECIDE, 4'd0, 2'd0);

      // Shrinking the building leaves a lift above the new top floor.
      settle();
      write_register(REG_FLOORS, 5'd3);
      write_register(REG_LIFTS, 5'd2);
      send_item(CMD_HALL_UP, 4'd9, 2'd0);
      send_item(CMD_CAR, 4'd1, 2'd3);
      send_item(CMD_CAR, 4'd2, 2'd1);
      repeat (3) send_item(CMD_DECIDE, 4'd0, 2'd0);

      settle();
      write_register(REG_FLOORS, 5'd2);
      write_register(REG_LIFTS, 5'd1);
      send_item(CMD_DECIDE, 4'd0, 2'd0);
      send_item(CMD_HALL_DOWN, 4'd1, 2'd0);
      repeat (2) send_item(CMD_DECIDE, 4'd0, 2'd0);

      for (ph = 0; ph < 6; ph++) begin
         settle();
         case (ph / 2)
            0: begin
               tx_idle_pct = 23;
               rx_idle_pct = 61;
            end
            1: begin
               tx_idle_pct = 61;
               rx_idle_pct = 23;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         write_register(REG_FLOORS, 5'(floors_plan[ph]));
         write_register(REG_LIFTS, 5'(lifts_plan[ph]));
         if (ph == 5) begin
            // The receiver stops for a long stretch while a run of decide items waits behind the first round.
            hold_requests++;
            repeat (30) send_item(CMD_DECIDE, 4'd0, 2'd0);
            settle();
         end
         repeat (80) send_random_item();
      end

      settle();
      sb.check_drained();
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* elevator_group_dispatcher.f */
hw/rtl/egd_pkg.sv
hw/rtl/elevator_group_dispatcher.sv
test/elevator_group_dispatcher_test.sv
